// ----- design/serial_frame_command_slave_assert.svh -----
// Assertion macros for the serial frame command slave
`ifndef SERIAL_FRAME_COMMAND_SLAVE_ASSERT_SVH
`define SERIAL_FRAME_COMMAND_SLAVE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on aclk, off while in reset
`define SFCS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sfcs assertion failed");
// next-cycle implication, sampled on aclk, off while in reset
`define SFCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sfcs assertion failed");
`else
`define SFCS_ASSERT_NOW(lbl, ante, cons)
`define SFCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/sfcs_pkg.sv -----
// Types, constants and the CRC step for the serial frame command slave
package sfcs_pkg;

    localparam int FrameLen = 6;
    localparam int AnswerLen = 3;
    localparam logic [15:0] CrcPoly = 16'h1021;
    localparam logic [15:0] CrcTop = 16'h8000;

    localparam logic [7:0] CMD_ANSWER = 8'h01;
    localparam logic [7:0] CMD_SUM = 8'h02;
    localparam logic [7:0] CMD_CLEAR = 8'h03;

    localparam logic IN_RX_BYTE = 1'b0;
    localparam logic IN_LOAD = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  rx_byte;
        logic [23:0] answer_payload;
    } sfcs_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic [15:0] sum_value;
        logic        last;
    } sfcs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DECIDE,
        ST_ACRC,
        ST_SEND,
        ST_SUM
    } sfcs_state_t;

    typedef struct packed {
        logic s_ready;
        logic emit;
        logic crc_run;
    } sfcs_ctrl_t;

    // One byte of CRC-16, MSB first, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int j = 0; j < 8; j++) begin
            if ((c & CrcTop) != 16'h0000) begin
                c = (c << 1) ^ CrcPoly;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/serial_frame_command_slave.sv -----
// Top level of the serial frame command slave
//
//  port group   dir   payload      role
//  s_*          in    sfcs_in_t    received byte or answer payload load
//  m_*          out   sfcs_out_t   answer byte or sum update
//  cfg_*        in    8 bits       slave address write
//
// A load or a non-final frame byte is only stored. The sixth byte runs the
// shared byte-wide CRC unit over four stored bytes, then a decide state;
// command 1 reruns it over the address and answer bytes and sends six words,
// one per free output cycle. s_ready is high only in the idle state; output
// stalls hold the sequencer. Reset is synchronous, active low, and sets the
// address to 1.
`include "serial_frame_command_slave_assert.svh"

module serial_frame_command_slave (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfcs_pkg::sfcs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sfcs_pkg::sfcs_out_t m_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);
    import sfcs_pkg::*;

    sfcs_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [2:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  addr_reg;
    logic [7:0]  frame_reg [FrameLen];
    logic [7:0]  answer_reg [AnswerLen];
    logic        m_valid_reg;
    sfcs_out_t   m_data_reg, m_data_next;

    sfcs_ctrl_t  ctrl;
    logic        out_free;
    logic        s_fire;
    logic [7:0]  crc_byte;
    logic [15:0] crc_step;
    logic        frame_ok;
    logic [7:0]  send_byte;
    logic        clear_answer;

    assign out_free = !m_valid_reg || m_ready;
    assign s_fire = s_valid && ctrl.s_ready;

    // Pick the byte fed to the shared CRC unit
    always_comb begin
        crc_byte = 8'h00;
        if (state_reg == ST_CHECK) begin
            crc_byte = frame_reg[{1'b0, step_reg[1:0]}];
        end else begin
            case (step_reg[1:0])
                2'd0:    crc_byte = addr_reg;
                2'd1:    crc_byte = answer_reg[0];
                2'd2:    crc_byte = answer_reg[1];
                default: crc_byte = answer_reg[2];
            endcase
        end
    end

    assign crc_step = crc16_byte(crc_reg, crc_byte);

    assign frame_ok = (frame_reg[0] == addr_reg) && (frame_reg[4] == crc_reg[7:0])
                      && (frame_reg[5] == crc_reg[15:8]);

    // Select the answer word for the current send step
    always_comb begin
        case (step_reg)
            3'd0:    send_byte = addr_reg;
            3'd1:    send_byte = answer_reg[0];
            3'd2:    send_byte = answer_reg[1];
            3'd3:    send_byte = answer_reg[2];
            3'd4:    send_byte = crc_reg[7:0];
            3'd5:    send_byte = crc_reg[15:8];
            default: send_byte = 8'h00;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        ctrl = '0;
        m_data_next = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.s_ready = 1'b1;
            end
            ST_CHECK, ST_ACRC: begin
                ctrl.crc_run = 1'b1;
            end
            ST_SEND: begin
                ctrl.emit = out_free;
                m_data_next.kind = KIND_BYTE;
                m_data_next.tx_byte = send_byte;
                m_data_next.last = (step_reg == 3'(FrameLen - 1));
            end
            ST_SUM: begin
                ctrl.emit = out_free;
                m_data_next.kind = KIND_SUM;
                m_data_next.sum_value = {frame_reg[2], frame_reg[3]};
                m_data_next.last = 1'b1;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // Sequencer next state, step, count and CRC
    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        count_next = count_reg;
        crc_next = crc_reg;
        clear_answer = 1'b0;
        // advance the CRC by one byte while the shared unit runs
        if (ctrl.crc_run) begin
            crc_next = crc_step;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.command == IN_RX_BYTE) begin
                    if (count_reg >= 3'(FrameLen - 1)) begin
                        count_next = 3'd0;
                        step_next = 3'd0;
                        crc_next = 16'h0000;
                        state_next = ST_CHECK;
                    end else begin
                        count_next = count_reg + 3'd1;
                    end
                end
            end
            ST_CHECK: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                step_next = 3'd0;
                state_next = ST_IDLE;
                if (frame_ok) begin
                    case (frame_reg[1])
                        CMD_ANSWER: begin
                            crc_next = 16'h0000;
                            state_next = ST_ACRC;
                        end
                        CMD_SUM: state_next = ST_SUM;
                        CMD_CLEAR: clear_answer = 1'b1;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACRC: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    step_next = 3'd0;
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (ctrl.emit) begin
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'(FrameLen - 1)) begin
                        clear_answer = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                if (ctrl.emit) begin
                    clear_answer = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers, address and answer payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= 3'd0;
            count_reg <= 3'd0;
            crc_reg <= 16'h0000;
            addr_reg <= 8'h01;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < AnswerLen; i++) begin
                answer_reg[i] <= 8'h00;
            end
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            count_reg <= count_next;
            crc_reg <= crc_next;
            if (cfg_we) begin
                addr_reg <= cfg_wdata;
            end
            // hold a word until taken, load the next when the slot is free
            if (ctrl.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (clear_answer) begin
                for (int i = 0; i < AnswerLen; i++) begin
                    answer_reg[i] <= 8'h00;
                end
            end else if (s_fire && s_data.command == IN_LOAD) begin
                answer_reg[0] <= s_data.answer_payload[23:16];
                answer_reg[1] <= s_data.answer_payload[15:8];
                answer_reg[2] <= s_data.answer_payload[7:0];
            end
        end
    end

    // Frame store and output word
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.command == IN_RX_BYTE && count_reg < 3'(FrameLen)) begin
            frame_reg[count_reg] <= s_data.rx_byte;
        end
        if (ctrl.emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_ready = ctrl.s_ready;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    `SFCS_ASSERT_NOW(a_count_range, 1'b1, count_reg < 3'(FrameLen))
    `SFCS_ASSERT_NOW(a_check_from_idle, state_reg == ST_CHECK && step_reg == 3'd0, $past(state_reg) == ST_IDLE)
    `SFCS_ASSERT_NOW(a_sum_is_last, m_valid_reg && m_data_reg.kind == KIND_SUM, m_data_reg.last)
    `SFCS_ASSERT_NEXT(a_send_last_to_idle, ctrl.emit && state_reg == ST_SEND && m_data_next.last, state_reg == ST_IDLE && m_valid_reg)

endmodule

// ----- verif/serial_frame_command_slave_tb.sv -----
// Self-checking testbench for the serial frame command slave
`timescale 1ns / 100ps

module serial_frame_command_slave_tb;
    import sfcs_pkg::*;

    // Tracks the slave's frame and payload state and the answer words it owes
    class answer_tracker;
        logic [7:0] slave_addr;
        logic [2:0] fill;
        logic [7:0] frame[FrameLen];
        logic [7:0] answer[AnswerLen];
        sfcs_out_t  answers_due[$];
        int         mismatches;

        function new();
            slave_addr = 8'h01;
            fill = 3'd0;
            foreach (frame[i]) frame[i] = 8'h00;
            foreach (answer[i]) answer[i] = 8'h00;
            mismatches = 0;
        endfunction

        // CRC-16, polynomial 0x1021, seed 0, bit-serial MSB first
        function logic [15:0] crc16(logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c, logic [7:0] d);
            logic [31:0] msg;
            logic [15:0] acc;
            logic        fb;
            msg = {a, b, c, d};
            acc = 16'h0000;
            for (int i = 31; i >= 0; i--) begin
                fb = acc[15] ^ msg[i];
                acc = {acc[14:0], 1'b0};
                if (fb) begin
                    acc = acc ^ CrcPoly;
                end
            end
            return acc;
        endfunction

        function void owe_byte(logic [7:0] b, logic fin);
            sfcs_out_t w;
            w.kind = KIND_BYTE;
            w.tx_byte = b;
            w.sum_value = 16'h0000;
            w.last = fin;
            answers_due.push_back(w);
        endfunction

        // Advance the state by one accepted input word
        function void take_word(sfcs_in_t w);
            logic [2:0]  idx;
            logic [15:0] crc;
            logic [15:0] ac;
            sfcs_out_t   s;
            if (w.command == IN_LOAD) begin
                answer[0] = w.answer_payload[23:16];
                answer[1] = w.answer_payload[15:8];
                answer[2] = w.answer_payload[7:0];
                return;
            end
            idx = fill;
            if (idx < FrameLen) begin
                frame[idx] = w.rx_byte;
            end
            if (int'(idx) + 1 < FrameLen) begin
                fill = idx + 3'd1;
                return;
            end
            fill = 3'd0;
            crc = crc16(frame[0], frame[1], frame[2], frame[3]);
            // drop frames with a foreign address or a bad CRC
            if (frame[0] != slave_addr || frame[4] != crc[7:0] || frame[5] != crc[15:8]) begin
                return;
            end
            case (frame[1])
                CMD_ANSWER: begin
                    ac = crc16(slave_addr, answer[0], answer[1], answer[2]);
                    owe_byte(slave_addr, 1'b0);
                    owe_byte(answer[0], 1'b0);
                    owe_byte(answer[1], 1'b0);
                    owe_byte(answer[2], 1'b0);
                    owe_byte(ac[7:0], 1'b0);
                    owe_byte(ac[15:8], 1'b1);
                    foreach (answer[i]) answer[i] = 8'h00;
                end
                CMD_SUM: begin
                    s.kind = KIND_SUM;
                    s.tx_byte = 8'h00;
                    s.sum_value = {frame[2], frame[3]};
                    s.last = 1'b1;
                    answers_due.push_back(s);
                    foreach (answer[i]) answer[i] = 8'h00;
                    foreach (frame[i]) frame[i] = 8'h00;
                end
                CMD_CLEAR: begin
                    foreach (answer[i]) answer[i] = 8'h00;
                    foreach (frame[i]) frame[i] = 8'h00;
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one output word with the oldest owed answer
        function void match_word(sfcs_out_t got);
            sfcs_out_t want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: kind=%0d tx=%02h sum=%04h last=%0d",
                             got.kind, got.tx_byte, got.sum_value, got.last);
                end
                return;
            end
            want = answers_due.pop_front();
            if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                got.sum_value !== want.sum_value || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: want kind=%0d tx=%02h sum=%04h last=%0d, got kind=%0d tx=%02h sum=%04h last=%0d",
                             want.kind, want.tx_byte, want.sum_value, want.last,
                             got.kind, got.tx_byte, got.sum_value, got.last);
                end
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sfcs_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sfcs_out_t m_data;
    logic      cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    answer_tracker sb = new();
    int  frame_pos = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    always #4 aclk = ~aclk;

    serial_frame_command_slave u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Observe both handshakes on the pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.take_word(s_data);
            end
            if (m_valid && m_ready) begin
                sb.match_word(m_data);
            end
        end
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 28);
            end
        end
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(sfcs_in_t w);
        int gap;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(99) < 28) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b);
        sfcs_in_t w;
        w.command = IN_RX_BYTE;
        w.rx_byte = b;
        w.answer_payload = 24'($urandom_range(24'hFFFFFF));
        send_word(w);
        frame_pos = (frame_pos + 1) % FrameLen;
    endtask

    task automatic send_load(logic [23:0] p);
        sfcs_in_t w;
        w.command = IN_LOAD;
        w.rx_byte = 8'($urandom_range(255));
        w.answer_payload = p;
        send_word(w);
    endtask

    // Send a six-byte frame, optionally with one CRC bit flipped and loads mixed in
    task automatic send_frame(logic [7:0] addr, logic [7:0] cmd, logic [7:0] b2,
                              logic [7:0] b3, bit corrupt, bit mix_loads);
        logic [7:0]  bytes[FrameLen];
        logic [15:0] crc;
        crc = sb.crc16(addr, cmd, b2, b3);
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        bytes[0] = addr;
        bytes[1] = cmd;
        bytes[2] = b2;
        bytes[3] = b3;
        bytes[4] = crc[7:0];
        bytes[5] = crc[15:8];
        for (int i = 0; i < FrameLen; i++) begin
            if (mix_loads && $urandom_range(19) == 0) begin
                send_load(24'($urandom_range(24'hFFFFFF)));
            end
            send_byte(bytes[i]);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly well-formed frames, with loads, stray bytes and broken frames
    task automatic run_random(int n_items, logic [7:0] addr);
        int sent;
        int r;
        logic [7:0] a;
        logic [7:0] cmd;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_load(($urandom_range(3) == 0) ? 24'hFFFFFF
                                                   : 24'($urandom_range(24'hFFFFFF)));
                sent++;
            end else if (r < 20) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                // realign to a frame boundary first
                while (frame_pos != 0) begin
                    send_byte(8'($urandom_range(255)));
                    sent++;
                end
                a = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : addr;
                case ($urandom_range(9))
                    0, 1, 2, 3: cmd = CMD_ANSWER;
                    4, 5:       cmd = CMD_SUM;
                    6, 7:       cmd = CMD_CLEAR;
                    default:    cmd = pick_byte();
                endcase
                send_frame(a, cmd, pick_byte(), pick_byte(), $urandom_range(9) == 0, 1'b1);
                sent += FrameLen;
            end
        end
    endtask

    // Release the input, wait for owed answers, then let the sequencer settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_address(logic [7:0] a);
        cfg_we <= 1'b1;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.slave_addr = a;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: full payload answer, sum extremes, bad CRC, clear
        send_load(24'hFFFFFF);
        send_frame(8'h01, CMD_ANSWER, 8'h00, 8'h00, 1'b0, 1'b0);
        send_frame(8'h01, CMD_SUM, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_load(24'h123456);
        send_frame(8'h01, CMD_ANSWER, 8'h5A, 8'hA5, 1'b1, 1'b0);
        send_frame(8'h01, CMD_CLEAR, 8'hFF, 8'h00, 1'b0, 1'b0);
        drain();

        write_address(8'h00);
        run_random(100, 8'h00);
        drain();

        write_address(8'hFF);
        no_idle = 1'b1;
        run_random(50, 8'hFF);
        no_idle = 1'b0;
        run_random(50, 8'hFF);
        drain();

        write_address(8'($urandom_range(2, 254)));
        hold_req = 1'b1;
        run_random(100, sb.slave_addr);
        drain();

        if (sb.mismatches == 0 && sb.answers_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- serial_frame_command_slave.f -----
+incdir+design
design/sfcs_pkg.sv
design/serial_frame_command_slave.sv
verif/serial_frame_command_slave_tb.sv
